// ----- design/assert_macros.svh -----
// Assertion macros used by the matrix inverse unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the following cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/m3inv_pkg.sv -----
// Types, constants and the product schedule of the 3x3 matrix inverse unit
package m3inv_pkg;

  // Index of the ninth element and of the ninth result
  localparam logic [3:0] LAST_ELEM = 4'd8;
  // Last entry of the product schedule (three determinant products close it)
  localparam logic [4:0] LAST_STEP = 5'd20;

  typedef enum logic [3:0] {
    S_LOAD,
    S_LDB,
    S_LDA,
    S_MUL,
    S_DET_CHK,
    S_DIV_LD,
    S_DIV_CHK,
    S_DIV_STEP,
    S_OUT
  } state_e;

  // Sequencer view handed to the datapath
  typedef struct packed {
    state_e     state;
    logic [4:0] step;
    logic [3:0] k;
    logic [3:0] load_cnt;
    logic       sing;
  } ctrl_t;

  // Datapath conditions handed back to the sequencer
  typedef struct packed {
    logic mul_done;
    logic acc_zero;
    logic div_ovf;
    logic out_free;
  } status_t;

  // One multiply-accumulate of the schedule
  typedef struct packed {
    logic [3:0] mplier;
    logic [3:0] mcand;
    logic       from_cof;
    logic       sub;
    logic       clr;
    logic       wr_cof;
  } mop_t;

  function automatic mop_t mk_op(logic [3:0] mplier, logic [3:0] mcand,
                                 logic from_cof, logic sub, logic clr, logic wr_cof);
    mop_t op;
    op.mplier   = mplier;
    op.mcand    = mcand;
    op.from_cof = from_cof;
    op.sub      = sub;
    op.clr      = clr;
    op.wr_cof   = wr_cof;
    return op;
  endfunction

  // Two products per cofactor (row-major), then the determinant along row 0
  function automatic mop_t prog_op(logic [4:0] step);
    mop_t op;
    case (step)
      5'd0:    op = mk_op(4'd4, 4'd8, 1'b0, 1'b0, 1'b1, 1'b0);
      5'd1:    op = mk_op(4'd5, 4'd7, 1'b0, 1'b1, 1'b0, 1'b1);
      5'd2:    op = mk_op(4'd7, 4'd2, 1'b0, 1'b0, 1'b1, 1'b0);
      5'd3:    op = mk_op(4'd8, 4'd1, 1'b0, 1'b1, 1'b0, 1'b1);
      5'd4:    op = mk_op(4'd1, 4'd5, 1'b0, 1'b0, 1'b1, 1'b0);
      5'd5:    op = mk_op(4'd2, 4'd4, 1'b0, 1'b1, 1'b0, 1'b1);
      5'd6:    op = mk_op(4'd5, 4'd6, 1'b0, 1'b0, 1'b1, 1'b0);
      5'd7:    op = mk_op(4'd3, 4'd8, 1'b0, 1'b1, 1'b0, 1'b1);
      5'd8:    op = mk_op(4'd8, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0);
      5'd9:    op = mk_op(4'd6, 4'd2, 1'b0, 1'b1, 1'b0, 1'b1);
      5'd10:   op = mk_op(4'd2, 4'd3, 1'b0, 1'b0, 1'b1, 1'b0);
      5'd11:   op = mk_op(4'd0, 4'd5, 1'b0, 1'b1, 1'b0, 1'b1);
      5'd12:   op = mk_op(4'd3, 4'd7, 1'b0, 1'b0, 1'b1, 1'b0);
      5'd13:   op = mk_op(4'd4, 4'd6, 1'b0, 1'b1, 1'b0, 1'b1);
      5'd14:   op = mk_op(4'd6, 4'd1, 1'b0, 1'b0, 1'b1, 1'b0);
      5'd15:   op = mk_op(4'd7, 4'd0, 1'b0, 1'b1, 1'b0, 1'b1);
      5'd16:   op = mk_op(4'd0, 4'd4, 1'b0, 1'b0, 1'b1, 1'b0);
      5'd17:   op = mk_op(4'd1, 4'd3, 1'b0, 1'b1, 1'b0, 1'b1);
      5'd18:   op = mk_op(4'd0, 4'd0, 1'b1, 1'b0, 1'b1, 1'b0);
      5'd19:   op = mk_op(4'd1, 4'd3, 1'b1, 1'b0, 1'b0, 1'b0);
      5'd20:   op = mk_op(4'd2, 4'd6, 1'b1, 1'b0, 1'b0, 1'b0);
      default: op = '0;
    endcase
    return op;
  endfunction

endpackage

// ----- design/m3inv_in_if.sv -----
// Request channel carrying one matrix element
interface m3inv_in_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink (input valid, input element, output ready);
endinterface

// ----- design/m3inv_out_if.sv -----
// Result channel carrying one inverse element with its flags
interface m3inv_out_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] inverse_element;
  logic                         singular;
  logic                         last;

  modport source (output valid, output inverse_element, output singular, output last,
                  input ready);
  modport sink (input valid, input inverse_element, input singular, input last,
                output ready);
endinterface

// ----- design/matrix3x3_inverse_unit.sv -----
// 3x3 fixed-point matrix inverse by adjugate and determinant, one shared adder.
// Nine elements are loaded, then the products are formed by shift-add (each stops
// once its remaining multiplier bits are zero), then each result comes from a
// restoring division, cut short if saturated and skipped if singular.
// A new matrix is accepted only once the last result of the previous one is in the output register.
// Reset clears the sequencer and output valid; element and cofactor stores are not cleared.
`include "assert_macros.svh"

module matrix3x3_inverse_unit import m3inv_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  m3inv_in_if.sink   in_i,
  m3inv_out_if.source out_o
);

  localparam int W    = DATA_WIDTH;
  localparam int CW   = 2 * DATA_WIDTH + 1;
  localparam int NW   = 2 * DATA_WIDTH + 2 * FRAC_BITS;
  localparam int AccW = (3 * DATA_WIDTH + 2 > DATA_WIDTH + 2 * FRAC_BITS + 2) ?
                        3 * DATA_WIDTH + 2 : DATA_WIDTH + 2 * FRAC_BITS + 2;

  ctrl_t   ctrl;
  status_t stat;
  mop_t    op;
  logic    in_acc;
  logic    load_wait;

  // Storage
  logic [W-1:0]    store_q [9];
  logic [CW-1:0]   cof_q [9];
  logic [AccW-1:0] acc_q, acc_d;
  logic [AccW-1:0] mcand_q, mcand_d;
  logic [W-1:0]    mplier_q, mplier_d;
  logic            eff_sub_q, eff_sub_d;
  logic [AccW-1:0] det_mag_q, det_mag_d;
  logic            det_neg_q, det_neg_d;
  logic            res_neg_q, res_neg_d;
  logic            ovf_q, ovf_d;

  // Output register
  logic            out_valid_q;
  logic [W-1:0]    out_elem_q;
  logic            out_sing_q;
  logic            out_last_q;
  logic            out_free;
  logic [W-1:0]    res_val;

  // Read ports and shared unit
  logic [3:0]      cof_idx;
  logic [W-1:0]    mcand_rd_q;
  logic [W-1:0]    mplier_rd_q;
  logic [CW-1:0]   cof_rd_q;
  logic [AccW-1:0] alu_a, alu_b, alu_res;
  logic            alu_sub;
  logic [AccW-1:0] rem_sh;
  logic            div_ge;
  logic [NW-1:0]   nmag;

  assign in_acc    = in_i.valid && in_i.ready;
  assign op        = prog_op(ctrl.step);
  assign out_free  = !out_valid_q || out_o.ready;
  assign load_wait = (ctrl.state == S_LOAD) && !(in_acc && (ctrl.load_cnt == LAST_ELEM));

  m3inv_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_acc_i   (in_acc),
    .stat_i     (stat),
    .in_ready_o (in_i.ready),
    .ctrl_o     (ctrl)
  );

  m3inv_alu #(
    .WIDTH (AccW)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res)
  );

  // Select the cofactor read for the next cycle: the next result in the output state
  always_comb begin
    case (ctrl.state)
      S_DET_CHK: cof_idx = '0;
      S_OUT:     cof_idx = (ctrl.k == LAST_ELEM) ? LAST_ELEM : ctrl.k + 4'd1;
      default:   cof_idx = op.mcand;
    endcase
  end

  // Shift the remainder up and bring in the next numerator bit
  assign rem_sh = {acc_q[AccW-2:0], mplier_q[W-1]};
  assign div_ge = !alu_res[AccW-1];
  assign nmag   = NW'(alu_res[2*W-1:0]) << (2 * FRAC_BITS);

  // Route operands into the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (ctrl.state)
      S_LDA: begin
        alu_b   = {{(AccW-W){mplier_rd_q[W-1]}}, mplier_rd_q};
        alu_sub = mplier_rd_q[W-1];
      end
      S_MUL: begin
        alu_a   = acc_q;
        alu_b   = mcand_q;
        alu_sub = eff_sub_q;
      end
      S_DET_CHK: begin
        alu_b   = acc_q;
        alu_sub = acc_q[AccW-1];
      end
      S_DIV_LD: begin
        alu_b   = {{(AccW-CW){cof_rd_q[CW-1]}}, cof_rd_q};
        alu_sub = cof_rd_q[CW-1];
      end
      S_DIV_CHK: begin
        alu_a   = acc_q;
        alu_b   = det_mag_q;
        alu_sub = 1'b1;
      end
      S_DIV_STEP: begin
        alu_a   = rem_sh;
        alu_b   = det_mag_q;
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  // Datapath register updates
  always_comb begin
    acc_d     = acc_q;
    mcand_d   = mcand_q;
    mplier_d  = mplier_q;
    eff_sub_d = eff_sub_q;
    det_mag_d = det_mag_q;
    det_neg_d = det_neg_q;
    res_neg_d = res_neg_q;
    ovf_d     = ovf_q;
    case (ctrl.state)
      S_LDB: begin
        if (op.clr) acc_d = '0;
      end
      S_LDA: begin
        mcand_d   = op.from_cof ? {{(AccW-CW){cof_rd_q[CW-1]}}, cof_rd_q}
                                : {{(AccW-W){mcand_rd_q[W-1]}}, mcand_rd_q};
        mplier_d  = alu_res[W-1:0];
        eff_sub_d = op.sub ^ mplier_rd_q[W-1];
      end
      S_MUL: begin
        if (mplier_q[0]) acc_d = alu_res;
        mcand_d  = {mcand_q[AccW-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[W-1:1]};
      end
      S_DET_CHK: begin
        det_mag_d = alu_res;
        det_neg_d = acc_q[AccW-1];
      end
      S_DIV_LD: begin
        acc_d     = AccW'(nmag >> W);
        mplier_d  = nmag[W-1:0];
        res_neg_d = cof_rd_q[CW-1] ^ det_neg_q;
      end
      S_DIV_CHK: ovf_d = div_ge;
      S_DIV_STEP: begin
        acc_d    = div_ge ? alu_res : rem_sh;
        mplier_d = {mplier_q[W-2:0], div_ge};
      end
      default: ;
    endcase
  end

  // Saturate the quotient into the output range
  always_comb begin
    if (ctrl.sing) begin
      res_val = '0;
    end else if (res_neg_q) begin
      if (ovf_q || (mplier_q[W-1] && (|mplier_q[W-2:0]))) res_val = {1'b1, {(W-1){1'b0}}};
      else res_val = ~mplier_q + 1'b1;
    end else begin
      if (ovf_q || mplier_q[W-1]) res_val = {1'b0, {(W-1){1'b1}}};
      else res_val = mplier_q;
    end
  end

  always_comb begin
    stat.mul_done = (mplier_q == '0);
    stat.acc_zero = (acc_q == '0);
    stat.div_ovf  = div_ge;
    stat.out_free = out_free;
  end

  // Hold elements and cofactors; register the read data for the next cycle
  always_ff @(posedge clk_i) begin
    if (in_acc) store_q[ctrl.load_cnt] <= in_i.element;
    if ((ctrl.state == S_MUL) && stat.mul_done && op.wr_cof) begin
      cof_q[ctrl.step[4:1]] <= acc_q[CW-1:0];
    end
    mcand_rd_q  <= store_q[op.mcand];
    mplier_rd_q <= store_q[op.mplier];
    cof_rd_q    <= cof_q[cof_idx];
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    mcand_q   <= mcand_d;
    mplier_q  <= mplier_d;
    eff_sub_q <= eff_sub_d;
    det_mag_q <= det_mag_d;
    det_neg_q <= det_neg_d;
    res_neg_q <= res_neg_d;
    ovf_q     <= ovf_d;
  end

  // Load the output register when it empties
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((ctrl.state == S_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((ctrl.state == S_OUT) && out_free) begin
      out_elem_q <= res_val;
      out_sing_q <= ctrl.sing;
      out_last_q <= (ctrl.k == LAST_ELEM);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.inverse_element = out_elem_q;
  assign out_o.singular        = out_sing_q;
  assign out_o.last            = out_last_q;

  `ASSERT_IMPLIES(a_sing_zero, out_valid_q && out_sing_q, out_elem_q == '0, "singular nonzero")
  `ASSERT_IMPLIES(a_rem_bound, ctrl.state == S_DIV_STEP, acc_q < det_mag_q, "remainder too large")
  `ASSERT_NEXT(a_load_hold, load_wait, ctrl.state == S_LOAD, "loading ended early")

endmodule

// ----- design/m3inv_alu.sv -----
// Shared add/subtract unit of the matrix inverse datapath
module m3inv_alu #(
  parameter int WIDTH = 98
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic             sub_i,
  output logic [WIDTH-1:0] res_o
);

  // Add, or subtract by inverting b and feeding in a carry
  assign res_o = a_i + (b_i ^ {WIDTH{sub_i}}) + {{(WIDTH-1){1'b0}}, sub_i};

endmodule

// ----- design/m3inv_ctrl.sv -----
// Sequencer of the matrix inverse unit: load, products, determinant, divisions
module m3inv_ctrl import m3inv_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_acc_i,
  input  status_t stat_i,
  output logic    in_ready_o,
  output ctrl_t   ctrl_o
);

  localparam int BW = $clog2(DATA_WIDTH);

  state_e          state_q, state_d;
  logic [4:0]      step_q, step_d;
  logic [3:0]      k_q, k_d;
  logic [3:0]      load_cnt_q, load_cnt_d;
  logic            sing_q, sing_d;
  logic [BW-1:0]   bit_cnt_q, bit_cnt_d;
  logic            bit_last;

  assign bit_last = (bit_cnt_q == BW'(DATA_WIDTH - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: begin
        if (in_acc_i && (load_cnt_q == LAST_ELEM)) state_d = S_LDB;
      end
      S_LDB: state_d = S_LDA;
      S_LDA: state_d = S_MUL;
      S_MUL: begin
        if (stat_i.mul_done) state_d = (step_q == LAST_STEP) ? S_DET_CHK : S_LDB;
      end
      S_DET_CHK: state_d = stat_i.acc_zero ? S_OUT : S_DIV_LD;
      S_DIV_LD: state_d = S_DIV_CHK;
      S_DIV_CHK: state_d = stat_i.div_ovf ? S_OUT : S_DIV_STEP;
      S_DIV_STEP: begin
        if (bit_last) state_d = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          if (k_q == LAST_ELEM) state_d = S_LOAD;
          else state_d = sing_q ? S_OUT : S_DIV_LD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Advance the counters
  always_comb begin
    step_d     = step_q;
    k_d        = k_q;
    load_cnt_d = load_cnt_q;
    sing_d     = sing_q;
    bit_cnt_d  = bit_cnt_q;
    case (state_q)
      S_LOAD: begin
        step_d = '0;
        if (in_acc_i) load_cnt_d = (load_cnt_q == LAST_ELEM) ? '0 : load_cnt_q + 4'd1;
      end
      S_MUL: begin
        if (stat_i.mul_done && (step_q != LAST_STEP)) step_d = step_q + 5'd1;
      end
      S_DET_CHK: begin
        k_d    = '0;
        sing_d = stat_i.acc_zero;
      end
      S_DIV_CHK: bit_cnt_d = '0;
      S_DIV_STEP: bit_cnt_d = bit_cnt_q + 1'b1;
      S_OUT: begin
        if (stat_i.out_free && (k_q != LAST_ELEM)) k_d = k_q + 4'd1;
      end
      default: ;
    endcase
  end

  // Drive the outputs
  always_comb begin
    in_ready_o      = (state_q == S_LOAD);
    ctrl_o.state    = state_q;
    ctrl_o.step     = step_q;
    ctrl_o.k        = k_q;
    ctrl_o.load_cnt = load_cnt_q;
    ctrl_o.sing     = sing_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      step_q     <= '0;
      k_q        <= '0;
      load_cnt_q <= '0;
      sing_q     <= 1'b0;
      bit_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      k_q        <= k_d;
      load_cnt_q <= load_cnt_d;
      sing_q     <= sing_d;
      bit_cnt_q  <= bit_cnt_d;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the 3x3 fixed-point matrix inverse unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import m3inv_pkg::*;

  localparam int DW           = 32;
  localparam int FB           = 16;
  // Wide enough for a cofactor scaled by 2^(2*FB) and for the determinant
  localparam int WW           = 4 * DW + 32;
  localparam int MATRICES     = 40;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 singular;
    logic                 last;
  } inv_elem_t;

  typedef enum int {MK_WIDE, MK_MODERATE, MK_TINY, MK_SINGULAR, MK_MIXED} mat_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Values driven onto the channels, known from time zero
  logic                 in_valid = 1'b0;
  logic signed [DW-1:0] in_elem  = '0;
  logic                 rx_ready = 1'b0;

  m3inv_in_if  #(.DATA_WIDTH(DW)) in_if ();
  m3inv_out_if #(.DATA_WIDTH(DW)) out_if ();

  assign in_if.valid   = in_valid;
  assign in_if.element = in_elem;
  assign out_if.ready  = rx_ready;

  matrix3x3_inverse_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor state and bookkeeping
  logic signed [DW-1:0] elem_store [9];
  logic [3:0]           elem_cnt = '0;
  inv_elem_t            inverse_q [$];
  logic signed [DW-1:0] element_q [$];
  int                   elements_total = 0;
  int                   elements_taken = 0;
  int                   mismatches     = 0;
  int                   results_seen   = 0;
  int                   burst_left     = 0;
  int                   gap_left       = 0;
  int                   hold_cnt       = 0;
  int                   hold_mark      = -1;
  int                   mode_left      = 0;
  rx_mode_e             rx_mode        = RX_OPEN;
  logic [1:0]           rx_phase       = '0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Store one element; on the ninth, invert the matrix exactly and queue nine results
  task automatic take_element(input logic signed [DW-1:0] elem);
    logic signed [WW-1:0] m   [9];
    logic signed [WW-1:0] cof [9];
    logic signed [WW-1:0] det, quot, sat_hi, sat_lo;
    inv_elem_t            res;
    int                   r, c, k;
    elem_store[elem_cnt] = elem;
    if (elem_cnt != LAST_ELEM) begin
      elem_cnt = elem_cnt + 1'b1;
    end else begin
      elem_cnt = '0;
      for (k = 0; k < 9; k++) m[k] = elem_store[k];
      // Adjugate entry (r, c) is the cofactor of (c, r)
      for (r = 0; r < 3; r++) begin
        for (c = 0; c < 3; c++) begin
          cof[r*3+c] = m[((c+1)%3)*3 + (r+1)%3] * m[((c+2)%3)*3 + (r+2)%3]
                     - m[((c+1)%3)*3 + (r+2)%3] * m[((c+2)%3)*3 + (r+1)%3];
        end
      end
      det    = m[0] * cof[0] + m[1] * cof[3] + m[2] * cof[6];
      sat_hi = '0;
      sat_hi[DW-2:0] = '1;
      sat_lo = ~sat_hi;
      for (k = 0; k < 9; k++) begin
        res.singular = (det == 0);
        res.last     = (k == LAST_ELEM);
        if (det == 0) begin
          res.value = '0;
        end else begin
          // Signed division truncates toward zero, then clamp to the output range
          quot = (cof[k] <<< (2 * FB)) / det;
          if (quot > sat_hi) quot = sat_hi;
          else if (quot < sat_lo) quot = sat_lo;
          res.value = quot[DW-1:0];
        end
        inverse_q.push_back(res);
      end
    end
  endtask

  task automatic add_row(input logic signed [DW-1:0] a, b, c);
    element_q.push_back(a);
    element_q.push_back(b);
    element_q.push_back(c);
  endtask

  // Queue one random matrix of the given flavour
  task automatic add_matrix(input mat_kind_e kind);
    logic signed [DW-1:0] a [9];
    mat_kind_e            pick;
    int                   k;
    for (k = 0; k < 9; k++) begin
      pick = kind;
      if (kind == MK_MIXED) pick = mat_kind_e'($urandom_range(0, 2));
      case (pick)
        MK_WIDE: a[k] = $urandom;
        MK_TINY: a[k] = int'($urandom_range(0, 64)) - 32;
        default: a[k] = int'($urandom_range(0, 1 << 20)) - (1 << 19);
      endcase
    end
    // Make the determinant exactly zero: dependent row or empty column
    if (kind == MK_SINGULAR) begin
      if ($urandom_range(0, 1) == 0) begin
        for (k = 6; k < 9; k++) a[k] = a[k-6] + a[k-3];
      end else begin
        k = $urandom_range(0, 2);
        a[k] = '0;
        a[k+3] = '0;
        a[k+6] = '0;
      end
    end
    for (k = 0; k < 9; k++) element_q.push_back(a[k]);
  endtask

  task automatic note_failure(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s at result %0d: expected %0d, got %0d",
               what, results_seen, want, got);
  endtask

  // Offer requests in bursts with random gaps; predict on every accepted request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        take_element(in_if.element);
        elements_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0 || element_q.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_elem  <= element_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // Hold the result channel off for a long stretch, twice in the run
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if ((results_seen == 45 || results_seen == 270) && results_seen != hold_mark) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_mark <= results_seen;
    end
  end

  // Check each accepted result against the oldest prediction; stall on a pattern
  always @(posedge clk_i) begin
    inv_elem_t want;
    logic      take;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        results_seen <= results_seen + 1;
        if (inverse_q.size() == 0) begin
          note_failure("unexpected result", 0, out_if.inverse_element);
        end else begin
          want = inverse_q.pop_front();
          if (out_if.inverse_element !== want.value)
            note_failure("inverse_element", want.value, out_if.inverse_element);
          if (out_if.singular !== want.singular)
            note_failure("singular", want.singular, out_if.singular);
          if (out_if.last !== want.last)
            note_failure("last", want.last, out_if.last);
        end
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      rx_phase = rx_phase + 1'b1;
      case (rx_mode)
        RX_OPEN:   take = 1'b1;
        RX_COIN:   take = 1'($urandom_range(0, 1));
        RX_EVERY4: take = (rx_phase != 2'd0);
        default:   take = ($urandom_range(0, 5) == 0);
      endcase
      if (hold_cnt != 0) take = 1'b0;
      rx_ready <= take;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int        n;
    int        pick;
    mat_kind_e kind;
    // Extreme diagonal: most negative, most positive and one
    add_row(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    add_row(32'h0000_0000, 32'h7fff_ffff, 32'h0000_0000);
    add_row(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    // All elements most negative: zero determinant
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    // Tiny pivots drive the inverse into both saturation limits
    add_row(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
    add_row(32'h0000_0000, 32'hffff_ffff, 32'h0000_0000);
    add_row(32'h0001_0000, 32'h0002_0000, 32'h7fff_ffff);
    for (n = 0; n < MATRICES; n++) begin
      pick = $urandom_range(0, 19);
      if (pick < 5)       kind = MK_WIDE;
      else if (pick < 12) kind = MK_MODERATE;
      else if (pick < 15) kind = MK_TINY;
      else if (pick < 18) kind = MK_SINGULAR;
      else                kind = MK_MIXED;
      add_matrix(kind);
    end
    elements_total = element_q.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (elements_taken != elements_total) @(posedge clk_i);
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && inverse_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
